>>> design/two_colour_line_fit_unit_assert.svh
// Assertion macros shared by the line fit unit modules.
`ifndef TWO_COLOUR_LINE_FIT_UNIT_ASSERT_SVH
`define TWO_COLOUR_LINE_FIT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define TCLF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tclf assertion failed");

// Next-cycle implication, disabled while in reset.
`define TCLF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tclf assertion failed");

`endif

>>> design/tclf_pkg.sv
package tclf_pkg;

  localparam int unsigned PALETTE_DEPTH   = 16;
  localparam int unsigned PALETTE_ENTRIES = 16;
  localparam int unsigned ROW_PIXELS      = 8;
  localparam int unsigned IDX_W           = 4;
  localparam int unsigned ERR_W           = 16;
  localparam logic [ERR_W-1:0] BEST_START = 16'h7FFF;

  typedef logic [ROW_PIXELS-1:0][IDX_W-1:0] pixel_row_t;
  typedef logic [PALETTE_DEPTH*PALETTE_DEPTH-1:0][ERR_W-1:0] err_table_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } tclf_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic step;
  } tclf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_pair;
    logic no_pairs;
  } tclf_status_t;

  localparam logic [23:0] PALETTE [PALETTE_DEPTH] = '{
    24'h000000, 24'h000000, 24'h21C842, 24'h5EDC78,
    24'h5455ED, 24'h7D76FC, 24'hD4524D, 24'h42EBF5,
    24'hFC5554, 24'hFF7978, 24'hD4C154, 24'hE6CE80,
    24'h21B03B, 24'hC95BBA, 24'hCCCCCC, 24'hFFFFFF
  };

  // Squared RGB distance for every index pair, truncated to 16 bits.
  // Index is {a, b}.
  function automatic err_table_t build_err_table();
    err_table_t  t;
    int          dr;
    int          dg;
    int          db;
    logic [31:0] s;
    t = '0;
    for (int a = 0; a < PALETTE_DEPTH; a++) begin
      for (int b = 0; b < PALETTE_DEPTH; b++) begin
        dr = int'(PALETTE[a][23:16]) - int'(PALETTE[b][23:16]);
        dg = int'(PALETTE[a][15:8])  - int'(PALETTE[b][15:8]);
        db = int'(PALETTE[a][7:0])   - int'(PALETTE[b][7:0]);
        s  = 32'(dr * dr + dg * dg + db * db);
        t[a * PALETTE_DEPTH + b] = s[ERR_W-1:0];
      end
    end
    return t;
  endfunction

  localparam err_table_t ERR_TABLE = build_err_table();

endpackage

>>> design/tclf_ctrl.sv
`include "two_colour_line_fit_unit_assert.svh"

module tclf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  tclf_pkg::tclf_status_t status,
  output tclf_pkg::tclf_cmd_t    cmd,
  output logic                  busy,
  output logic                  out_valid
);
  import tclf_pkg::*;

  tclf_state_t state_r;
  tclf_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (status.no_pairs || status.last_pair) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_RUN: begin
        cmd.step = !status.no_pairs;
      end
      ST_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  `TCLF_ASSERT_NOW(a_valid_busy, clk, rst_n, out_valid, busy)
  `TCLF_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy && !out_valid)
  `TCLF_ASSERT_NEXT(a_valid_pulse, clk, rst_n, out_valid, !out_valid && !busy)
  `TCLF_ASSERT_NOW(a_step_busy, clk, rst_n, cmd.step || !busy, !cmd.load || !busy)

endmodule

>>> design/tclf_dp.sv
`include "two_colour_line_fit_unit_assert.svh"

module tclf_dp #(
  parameter int unsigned PALETTE_ENTRIES = tclf_pkg::PALETTE_ENTRIES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tclf_pkg::tclf_cmd_t    cmd,
  input  tclf_pkg::pixel_row_t   pixels,
  output tclf_pkg::tclf_status_t status,
  output logic [7:0]            pattern_bits,
  output logic [7:0]            colour_byte
);
  import tclf_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);
  localparam logic [IDX_W-1:0] LAST_LO  = IDX_W'(PALETTE_ENTRIES - 2);
  localparam logic             NO_PAIRS = (PALETTE_ENTRIES < 3);

  pixel_row_t             px_r;
  logic [IDX_W-1:0]       lo_r, lo_nxt;
  logic [IDX_W-1:0]       hi_r, hi_nxt;
  logic [ERR_W-1:0]       best_r;
  logic [ROW_PIXELS-1:0]  pat_r;
  logic [7:0]             col_r;

  logic [ROW_PIXELS-1:0]  pat_try;
  logic [ERR_W-1:0]       sum_try;
  logic                   abandon;
  logic                   better;

  // One pair per cycle: all eight pixels in parallel, prefix sums checked
  // against the running best for the early reject.
  always_comb begin
    logic [ERR_W-1:0] e1;
    logic [ERR_W-1:0] e2;
    logic             take_hi;
    pat_try = '0;
    sum_try = '0;
    abandon = 1'b0;
    for (int i = 0; i < ROW_PIXELS; i++) begin
      e1      = ERR_TABLE[{px_r[i], lo_r}];
      e2      = ERR_TABLE[{px_r[i], hi_r}];
      take_hi = e1 > e2;
      pat_try[ROW_PIXELS-1-i] = take_hi;
      sum_try = sum_try + (take_hi ? e2 : e1);
      if (sum_try > best_r) abandon = 1'b1;
    end
    better = !abandon && (sum_try < best_r);
  end

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (hi_r == LAST_IDX) begin
      lo_nxt = lo_r + 1'b1;
      hi_nxt = lo_r + IDX_W'(2);
    end else begin
      hi_nxt = hi_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= '0;
      hi_r <= '0;
    end else if (cmd.load) begin
      lo_r <= IDX_W'(1);
      hi_r <= IDX_W'(2);
    end else if (cmd.step) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r   <= pixels;
      best_r <= BEST_START;
      pat_r  <= '0;
      col_r  <= '0;
    end else if (cmd.step && better) begin
      best_r <= sum_try;
      pat_r  <= pat_try;
      col_r  <= {hi_r, lo_r};
    end
  end

  assign status.last_pair = (hi_r == LAST_IDX) && (lo_r == LAST_LO);
  assign status.no_pairs  = NO_PAIRS;
  assign pattern_bits     = pat_r;
  assign colour_byte      = col_r;

  `TCLF_ASSERT_NOW(a_pair_order, clk, rst_n, cmd.step, (hi_r > lo_r) && (lo_r != '0))
  `TCLF_ASSERT_NEXT(a_load_init, clk, rst_n, cmd.load, (lo_r == IDX_W'(1)) && (best_r == BEST_START))

endmodule

>>> design/two_colour_line_fit_unit.sv
// Two-colour line fit unit. Pulse start with eight 4-bit palette indices
// while busy is low; the row is taken at that edge. The unit then tries
// every colour pair c1 < c2 from 1 to PALETTE_ENTRIES-1, one pair per clock
// in a single shared evaluation stage; busy stays high from after the accept
// until the result is shown, so no new row is taken while a sweep runs. The
// result appears on out_pattern_bits and out_colour_byte for exactly one
// cycle, flagged by out_valid; the receiver cannot stall it, so it must be
// captured then. busy stays high through that cycle. out_colour_byte is c2
// in the upper nibble and c1 in the lower; both outputs are zero if no pair
// beat the starting bound.
module two_colour_line_fit_unit #(
  parameter int unsigned PALETTE_ENTRIES = tclf_pkg::PALETTE_ENTRIES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [3:0] in_pixel_0,
  input  logic [3:0] in_pixel_1,
  input  logic [3:0] in_pixel_2,
  input  logic [3:0] in_pixel_3,
  input  logic [3:0] in_pixel_4,
  input  logic [3:0] in_pixel_5,
  input  logic [3:0] in_pixel_6,
  input  logic [3:0] in_pixel_7,
  output logic       out_valid,
  output logic [7:0] out_pattern_bits,
  output logic [7:0] out_colour_byte
);
  import tclf_pkg::*;

  tclf_cmd_t    cmd;
  tclf_status_t status;
  pixel_row_t   pixels;

  // Pixel 0 sits at index 0; the datapath puts it at the pattern MSB.
  assign pixels = {in_pixel_7, in_pixel_6, in_pixel_5, in_pixel_4,
                   in_pixel_3, in_pixel_2, in_pixel_1, in_pixel_0};

  // Sequencer: idle, sweep the pairs, present the result request.
  tclf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Pair counters, error table lookups and running best.
  tclf_dp #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .pixels       (pixels),
    .status       (status),
    .pattern_bits (out_pattern_bits),
    .colour_byte  (out_colour_byte)
  );

endmodule

>>> test/tclf_fit_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the line fit unit, works out the expected fit for
// every accepted request and compares it with each result as it appears.
module tclf_fit_checker #(
  parameter int unsigned PALETTE_ENTRIES = tclf_pkg::PALETTE_ENTRIES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic [3:0] in_pixel_0,
  input  logic [3:0] in_pixel_1,
  input  logic [3:0] in_pixel_2,
  input  logic [3:0] in_pixel_3,
  input  logic [3:0] in_pixel_4,
  input  logic [3:0] in_pixel_5,
  input  logic [3:0] in_pixel_6,
  input  logic [3:0] in_pixel_7,
  input  logic       out_valid,
  input  logic [7:0] out_pattern_bits,
  input  logic [7:0] out_colour_byte,
  output int         fail_count,
  output int         fits_pending,
  output int         fits_checked,
  output int         empty_fits
);

  typedef struct packed {
    logic [7:0] pattern;
    logic [7:0] colours;
  } line_fit_t;

  // 0xRRGGBB per palette index
  localparam logic [23:0] RGB_ROM [16] = '{
    24'h000000, 24'h000000, 24'h21C842, 24'h5EDC78,
    24'h5455ED, 24'h7D76FC, 24'hD4524D, 24'h42EBF5,
    24'hFC5554, 24'hFF7978, 24'hD4C154, 24'hE6CE80,
    24'h21B03B, 24'hC95BBA, 24'hCCCCCC, 24'hFFFFFF
  };

  line_fit_t fit_q[$];

  function automatic logic [15:0] rgb_dist_sq(logic [3:0] a, logic [3:0] b);
    int          dr;
    int          dg;
    int          db;
    logic [31:0] s;
    dr = int'(RGB_ROM[a][23:16]) - int'(RGB_ROM[b][23:16]);
    dg = int'(RGB_ROM[a][15:8])  - int'(RGB_ROM[b][15:8]);
    db = int'(RGB_ROM[a][7:0])   - int'(RGB_ROM[b][7:0]);
    s  = 32'(dr * dr) + 32'(dg * dg) + 32'(db * db);
    return s[15:0];
  endfunction

  // Row word: pixel 0 in bits 31:28, pixel 7 in bits 3:0.
  function automatic line_fit_t best_line_fit(logic [31:0] row);
    logic [15:0] bound;
    logic [15:0] acc;
    logic [15:0] e_lo;
    logic [15:0] e_hi;
    logic [7:0]  bits;
    logic [3:0]  px;
    line_fit_t   win;
    win   = '0;
    bound = tclf_pkg::BEST_START;
    for (int lo = 1; lo < PALETTE_ENTRIES && lo < 16; lo++) begin
      for (int hi = lo + 1; hi < PALETTE_ENTRIES && hi < 16; hi++) begin
        acc  = '0;
        bits = '0;
        for (int p = 0; p < 8; p++) begin
          px   = row[31 - 4 * p -: 4];
          e_lo = rgb_dist_sq(px, 4'(lo));
          e_hi = rgb_dist_sq(px, 4'(hi));
          bits = {bits[6:0], e_lo > e_hi};
          acc  = acc + ((e_lo > e_hi) ? e_hi : e_lo);   // wraps at 16 bits
          if (acc > bound) break;                        // pair abandoned
        end
        if (acc < bound) begin
          bound       = acc;
          win.pattern = bits;
          win.colours = {4'(hi), 4'(lo)};
        end
      end
    end
    return win;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
    fail_count++;
    $display("%0t ns: MISMATCH %s: expected %02h, got %02h", $time, what, want, got);
  endtask

  initial begin
    fail_count   = 0;
    fits_pending = 0;
    fits_checked = 0;
    empty_fits   = 0;
  end

  always @(posedge clk) begin
    line_fit_t want;
    if (rst_n) begin
      // result first, so a request taken at the same edge is not matched to it
      if (out_valid) begin
        if (fit_q.size() == 0) begin
          report_mismatch("result with no request outstanding", 8'h00, out_colour_byte);
        end else begin
          want = fit_q.pop_front();
          if (out_pattern_bits !== want.pattern)
            report_mismatch("pattern_bits", want.pattern, out_pattern_bits);
          if (out_colour_byte !== want.colours)
            report_mismatch("colour_byte", want.colours, out_colour_byte);
          fits_checked++;
          if (want.colours == 8'h00) empty_fits++;
        end
      end
      if (start && !busy)
        fit_q.push_back(best_line_fit({in_pixel_0, in_pixel_1, in_pixel_2, in_pixel_3,
                                       in_pixel_4, in_pixel_5, in_pixel_6, in_pixel_7}));
      fits_pending = fit_q.size();
    end
  end

endmodule

>>> test/two_colour_line_fit_unit_tb.sv
`timescale 1ns / 1ps

// Top of the line fit bench: clock, reset, request stimulus, watchdog and
// the verdict. All prediction and comparison sits in the checker.
module two_colour_line_fit_unit_tb;

  localparam int unsigned FIT_ENTRIES   = tclf_pkg::PALETTE_ENTRIES;
  localparam int          RANDOM_ROWS   = 1500;
  localparam int          WATCHDOG_LIM  = 4000;  // longest gap + one full sweep, many times
  localparam int          DRAIN_CYCLES  = 150;   // a little over one full sweep

  // Row shapes for the random part
  typedef enum int {
    ROW_NOISE,
    ROW_TWO_COLOUR,
    ROW_THREE_COLOUR,
    ROW_UNIFORM
  } row_shape_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [3:0] in_pixel_0;
  logic [3:0] in_pixel_1;
  logic [3:0] in_pixel_2;
  logic [3:0] in_pixel_3;
  logic [3:0] in_pixel_4;
  logic [3:0] in_pixel_5;
  logic [3:0] in_pixel_6;
  logic [3:0] in_pixel_7;
  logic       out_valid;
  logic [7:0] out_pattern_bits;
  logic [7:0] out_colour_byte;

  int fail_count;
  int fits_pending;
  int fits_checked;
  int empty_fits;
  int rows_issued;
  int idle_cycles;
  int burst_left;

  // 8 ns period
  always #4 clk = ~clk;

  two_colour_line_fit_unit #(
    .PALETTE_ENTRIES (FIT_ENTRIES)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_pixel_0       (in_pixel_0),
    .in_pixel_1       (in_pixel_1),
    .in_pixel_2       (in_pixel_2),
    .in_pixel_3       (in_pixel_3),
    .in_pixel_4       (in_pixel_4),
    .in_pixel_5       (in_pixel_5),
    .in_pixel_6       (in_pixel_6),
    .in_pixel_7       (in_pixel_7),
    .out_valid        (out_valid),
    .out_pattern_bits (out_pattern_bits),
    .out_colour_byte  (out_colour_byte)
  );

  tclf_fit_checker #(
    .PALETTE_ENTRIES (FIT_ENTRIES)
  ) u_fit_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_pixel_0       (in_pixel_0),
    .in_pixel_1       (in_pixel_1),
    .in_pixel_2       (in_pixel_2),
    .in_pixel_3       (in_pixel_3),
    .in_pixel_4       (in_pixel_4),
    .in_pixel_5       (in_pixel_5),
    .in_pixel_6       (in_pixel_6),
    .in_pixel_7       (in_pixel_7),
    .out_valid        (out_valid),
    .out_pattern_bits (out_pattern_bits),
    .out_colour_byte  (out_colour_byte),
    .fail_count       (fail_count),
    .fits_pending     (fits_pending),
    .fits_checked     (fits_checked),
    .empty_fits       (empty_fits)
  );

  // Directed rows, pixel 0 in the top nibble:
  //   uniform rows (every pair holding a matching colour ties, so the first such pair must hold),
  //   the two identical blacks, extreme indices, full ramps,
  //   high contrast mixes aimed at large or wrapped sums (perhaps no pair at all),
  //   near colours where a pixel can sit equally far from both of a pair.
  localparam logic [31:0] DIRECTED_ROWS [22] = '{
    32'h00000000, 32'hFFFFFFFF, 32'h11111111, 32'h01010101,
    32'h0F0F0F0F, 32'hF0F0F0F0, 32'h0000000F, 32'hF0000000,
    32'h01234567, 32'h89ABCDEF, 32'hFEDCBA98, 32'h2F4F8F6F,
    32'h9E3C7D5B, 32'h6D9A4C7B, 32'h2468ACE0, 32'h88888889,
    32'h77777770, 32'hEEEEEEEF, 32'h55555555, 32'hAAAAAAAA,
    32'hF9E8D7C6, 32'h3B5D7F1E
  };

  // ---------------------------------------------------------------------------
  // Watchdog: any cycle with neither a request taken nor a result shown counts
  // towards the limit. Covers a hang in reset clearing as well as later on.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIM) begin
        $display("Watchdog: %0d cycles with no activity, %0d fits still owed",
                 idle_cycles, fits_pending);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Gap before the next request: mostly none or short, now and then long enough
  // to land past the end of a whole sweep. Bursts give stretches with no gaps.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 40);
    return $urandom_range(60, 300);
  endfunction

  function automatic logic [31:0] pick_row();
    row_shape_t  shape;
    logic [3:0]  ca;
    logic [3:0]  cb;
    logic [3:0]  cc;
    logic [31:0] row;
    int          r;
    r  = $urandom_range(0, 9);
    ca = 4'($urandom);
    cb = 4'($urandom);
    cc = 4'($urandom);
    if (r < 3)      shape = ROW_NOISE;
    else if (r < 7) shape = ROW_TWO_COLOUR;
    else if (r < 9) shape = ROW_THREE_COLOUR;
    else            shape = ROW_UNIFORM;
    row = $urandom;
    for (int p = 0; p < 8; p++) begin
      case (shape)
        ROW_TWO_COLOUR:   row[31 - 4 * p -: 4] = $urandom_range(0, 1) ? cb : ca;
        ROW_THREE_COLOUR: begin
          r = $urandom_range(0, 2);
          row[31 - 4 * p -: 4] = (r == 0) ? ca : (r == 1) ? cb : cc;
        end
        ROW_UNIFORM:      row[31 - 4 * p -: 4] = ca;
        default:          ;
      endcase
    end
    return row;
  endfunction

  // Present one request from the falling edge and hold it until a rising edge
  // finds busy low. start stays high on return; the caller lowers it or follows
  // straight on with the next request.
  task automatic issue_row(input logic [31:0] row);
    @(negedge clk);
    start      <= 1'b1;
    in_pixel_0 <= row[31:28];
    in_pixel_1 <= row[27:24];
    in_pixel_2 <= row[23:20];
    in_pixel_3 <= row[19:16];
    in_pixel_4 <= row[15:12];
    in_pixel_5 <= row[11:8];
    in_pixel_6 <= row[7:4];
    in_pixel_7 <= row[3:0];
    do
      @(posedge clk);
    while (busy);
    rows_issued++;
  endtask

  // start held low while idle; pixel ports carry noise meanwhile, which must be ignored
  task automatic idle_for(input int n);
    repeat (n) begin
      @(negedge clk);
      start      <= 1'b0;
      in_pixel_0 <= 4'($urandom);
      in_pixel_1 <= 4'($urandom);
      in_pixel_2 <= 4'($urandom);
      in_pixel_3 <= 4'($urandom);
      in_pixel_4 <= 4'($urandom);
      in_pixel_5 <= 4'($urandom);
      in_pixel_6 <= 4'($urandom);
      in_pixel_7 <= 4'($urandom);
    end
  endtask

  task automatic gap_after_row();
    if (burst_left > 0) begin
      burst_left--;
    end else if ($urandom_range(0, 99) < 3) begin
      burst_left = $urandom_range(10, 30);
    end else begin
      idle_for(pick_gap());
    end
  endtask

  initial begin
    // known values on every input from time zero
    rst_n       = 1'b0;
    start       = 1'b0;
    in_pixel_0  = '0;
    in_pixel_1  = '0;
    in_pixel_2  = '0;
    in_pixel_3  = '0;
    in_pixel_4  = '0;
    in_pixel_5  = '0;
    in_pixel_6  = '0;
    in_pixel_7  = '0;
    rows_issued = 0;
    idle_cycles = 0;
    burst_left  = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part
    foreach (DIRECTED_ROWS[i]) begin
      issue_row(DIRECTED_ROWS[i]);
      gap_after_row();
    end

    // Random part: mostly tile-like rows of two or three colours, some noise
    for (int n = 0; n < RANDOM_ROWS; n++) begin
      issue_row(pick_row());
      gap_after_row();
    end
    idle_for(1);

    // every request answered, then let the last sweep settle
    while (fits_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Issued %0d rows (%0d directed), checked %0d fits, %0d with no pair found.",
             rows_issued, $size(DIRECTED_ROWS), fits_checked, empty_fits);
    $display("Mismatches: %0d, fits still owed: %0d.", fail_count, fits_pending);
    if (fail_count == 0 && fits_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
